FILE: hw/rtl/kie_pkg.sv
// shared constants, command codes and control/status types of the k-means iteration engine
package kie_pkg;

	localparam int COORD_W    = 16;
	localparam int SUM_W      = 32;
	localparam int ENERGY_W   = 48;
	localparam int ITER_W     = 16;
	localparam int CLU_ID_W   = 3;
	localparam int COORD_ID_W = 3;
	localparam int ITEM_W     = 10;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 11;
	localparam int PC_W       = 11;
	localparam int KC_W       = 4;
	localparam int DC_W       = 4;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 88;

	localparam int DEF_MAX_POINTS   = 1024;
	localparam int DEF_MAX_CLUSTERS = 8;
	localparam int DEF_MAX_DIMS     = 8;

	localparam logic [CMD_W-1:0] CMD_LOAD_POINT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_CENT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN        = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT     = 2'd2;

	// where the datapath takes its cluster index from
	localparam logic [1:0] SEL_CTR   = 2'd0;
	localparam logic [1:0] SEL_BEST  = 2'd1;
	localparam logic [1:0] SEL_CLASS = 2'd2;

	typedef struct packed {
		logic       ld_point;
		logic       ld_cent;
		logic       run_start;
		logic       clr;
		logic       pt_rd;
		logic       cen_rd;
		logic       sum_rd;
		logic       cls_rd;
		logic [1:0] clu_sel;
		logic       diff_ld;
		logic       sq_acc;
		logic       acc_first;
		logic       best_ld;
		logic       best_first;
		logic       cls_wr;
		logic       cnt_inc;
		logic       acc_wr;
		logic       moved_clr;
		logic       div_start;
		logic       cent_upd;
		logic       sqrt_start;
		logic       energy_add;
		logic       iter_inc;
		logic       out_ld;
		logic       out_final;
	} kie_ctl_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic cnt_zero;
	} kie_stat_t;

endpackage

FILE: hw/rtl/kie_ram.sv
// generic single-write, single-read ram with registered read data
module kie_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/kie_div.sv
// iterative restoring divider, signed dividend by unsigned divisor, truncating toward zero
module kie_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic             neg_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_sub;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den};
	assign rem_sub = rem_sh - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= cnt_q == CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			num_q <= num[NUM_W-1] ? -num : num;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -num_q : num_q;

endmodule

FILE: hw/rtl/kie_isqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module kie_isqrt #(
	parameter int X_W = 35
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [X_W-1:0]         x,
	output logic                   done,
	output logic [(X_W+1)/2-1:0]   root
);

	localparam int RT_W  = (X_W + 1) / 2;
	localparam int PAD_W = 2 * RT_W;
	localparam int CNT_W = $clog2(RT_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [PAD_W-1:0]  x_q;
	logic [RT_W+1:0]   rem_q;
	logic [RT_W-1:0]   root_q;
	logic [RT_W+3:0]   rem_sh;
	logic [RT_W+3:0]   test;
	logic              ge;
	logic [RT_W+3:0]   rem_sub;

	assign rem_sh  = {rem_q, x_q[PAD_W-1:PAD_W-2]};
	assign test    = (RT_W+4)'({root_q, 2'b01});
	assign ge      = rem_sh >= test;
	assign rem_sub = rem_sh - test;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(RT_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= cnt_q == CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= PAD_W'(x);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			x_q    <= {x_q[PAD_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[RT_W+1:0] : rem_sh[RT_W+1:0];
			root_q <= {root_q[RT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hw/rtl/kie_datapath.sv
// datapath: stores, distance accumulator, cluster sums, divider, square root and result register
module kie_datapath
	import kie_pkg::*;
#(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_DIMS     = DEF_MAX_DIMS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kie_ctl_t                        ctl,
	input  logic [$clog2(MAX_POINTS)-1:0]   p_idx,
	input  logic [$clog2(MAX_CLUSTERS)-1:0] c_idx,
	input  logic [$clog2(MAX_DIMS)-1:0]     k_idx,
	input  logic [ITEM_W-1:0]               item_index,
	input  logic [COORD_ID_W-1:0]           coord_index,
	input  logic [COORD_W-1:0]              coord_value,
	output kie_stat_t                       stat,
	output logic [CLU_ID_W-1:0]             cluster_id,
	output logic [COORD_ID_W-1:0]           coord_id,
	output logic [COORD_W-1:0]              centroid_value,
	output logic                            cluster_moved,
	output logic [ENERGY_W-1:0]             total_energy,
	output logic [ITER_W-1:0]               iteration_count,
	output logic                            out_final
);

	localparam int CIW    = $clog2(MAX_CLUSTERS);
	localparam int PT_D   = MAX_POINTS * MAX_DIMS;
	localparam int PT_AW  = $clog2(PT_D);
	localparam int CEN_D  = MAX_CLUSTERS * MAX_DIMS;
	localparam int CEN_AW = $clog2(CEN_D);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int DST_W  = 2 * COORD_W + $clog2(MAX_DIMS);
	localparam int RT_W   = (DST_W + 1) / 2;

	logic [CIW-1:0]      clu;
	logic [CIW-1:0]      cls_rdata;
	logic [COORD_W-1:0]  pt_rdata;
	logic [COORD_W-1:0]  cen_rdata;
	logic [SUM_W-1:0]    sum_rdata;
	logic [PT_AW-1:0]    pt_raddr;
	logic [PT_AW-1:0]    pt_waddr;
	logic [CEN_AW-1:0]   cen_addr;
	logic [CEN_AW-1:0]   cen_ld_addr;
	logic                ld_pt_ok;
	logic                ld_cen_ok;
	logic                upd_we;
	logic                cen_we;
	logic [CEN_AW-1:0]   cen_waddr;
	logic [COORD_W-1:0]  cen_wdata;
	logic [SUM_W-1:0]    sum_wdata;
	logic signed [COORD_W:0] diff;
	logic [COORD_W:0]    abs_d;
	logic [COORD_W-1:0]  abs_q;
	logic [2*COORD_W-1:0] sq;
	logic [DST_W-1:0]    acc_q;
	logic [DST_W-1:0]    best_q;
	logic [CIW-1:0]      bi_q;
	logic signed [SUM_W:0] sum_ext;
	logic [SUM_W-1:0]    sum_sat;
	logic [CNT_W-1:0]    cnt_q [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0] moved_q;
	logic                div_done;
	logic [SUM_W-1:0]    quo;
	logic                sqrt_done;
	logic [RT_W-1:0]     root;
	logic [ENERGY_W-1:0] energy_q;
	logic [ENERGY_W:0]   energy_sum;
	logic [ITER_W-1:0]   iter_q;

	always_comb begin
		unique case (ctl.clu_sel)
			SEL_BEST:  clu = bi_q;
			SEL_CLASS: clu = cls_rdata;
			default:   clu = c_idx;
		endcase
	end

	assign pt_raddr    = PT_AW'(32'(p_idx) * MAX_DIMS + 32'(k_idx));
	assign pt_waddr    = PT_AW'(32'(item_index) * MAX_DIMS + 32'(coord_index));
	assign cen_addr    = CEN_AW'(32'(clu) * MAX_DIMS + 32'(k_idx));
	assign cen_ld_addr = CEN_AW'(32'(item_index) * MAX_DIMS + 32'(coord_index));
	assign ld_pt_ok    = ctl.ld_point && (32'(item_index) < MAX_POINTS)
		&& (32'(coord_index) < MAX_DIMS);
	assign ld_cen_ok   = ctl.ld_cent && (32'(item_index) < MAX_CLUSTERS)
		&& (32'(coord_index) < MAX_DIMS);

	// centroid rewritten only when the new mean differs from the stored one
	assign upd_we    = ctl.cent_upd && div_done && (quo[COORD_W-1:0] != cen_rdata);
	assign cen_we    = ld_cen_ok || upd_we;
	assign cen_waddr = ctl.ld_cent ? cen_ld_addr : cen_addr;
	assign cen_wdata = ctl.ld_cent ? coord_value : quo[COORD_W-1:0];

	assign sum_ext = $signed({sum_rdata[SUM_W-1], sum_rdata})
		+ (SUM_W+1)'($signed(pt_rdata));
	always_comb begin
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end
	assign sum_wdata = ctl.clr ? '0 : sum_sat;

	kie_ram #(.WIDTH(COORD_W), .DEPTH(PT_D)) u_point_ram (
		.clk   (clk),
		.we    (ld_pt_ok),
		.waddr (pt_waddr),
		.wdata (coord_value),
		.re    (ctl.pt_rd),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	kie_ram #(.WIDTH(COORD_W), .DEPTH(CEN_D)) u_cent_ram (
		.clk   (clk),
		.we    (cen_we),
		.waddr (cen_waddr),
		.wdata (cen_wdata),
		.re    (ctl.cen_rd),
		.raddr (cen_addr),
		.rdata (cen_rdata)
	);

	kie_ram #(.WIDTH(SUM_W), .DEPTH(CEN_D)) u_sum_ram (
		.clk   (clk),
		.we    (ctl.clr || ctl.acc_wr),
		.waddr (cen_addr),
		.wdata (sum_wdata),
		.re    (ctl.sum_rd),
		.raddr (cen_addr),
		.rdata (sum_rdata)
	);

	kie_ram #(.WIDTH(CIW), .DEPTH(MAX_POINTS)) u_class_ram (
		.clk   (clk),
		.we    (ctl.cls_wr),
		.waddr (p_idx),
		.wdata (bi_q),
		.re    (ctl.cls_rd),
		.raddr (p_idx),
		.rdata (cls_rdata)
	);

	kie_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (sum_rdata),
		.den    (cnt_q[clu]),
		.done   (div_done),
		.quo    (quo)
	);

	kie_isqrt #(.X_W(DST_W)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.sqrt_start),
		.x      (acc_q),
		.done   (sqrt_done),
		.root   (root)
	);

	assign diff  = $signed({cen_rdata[COORD_W-1], cen_rdata})
		- $signed({pt_rdata[COORD_W-1], pt_rdata});
	assign abs_d = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
	assign sq    = abs_q * abs_q;

	assign energy_sum = (ENERGY_W+1)'(energy_q) + (ENERGY_W+1)'(root);

	always_ff @(posedge clk) begin
		if (ctl.diff_ld) begin
			abs_q <= abs_d[COORD_W-1:0];
		end
		if (ctl.sq_acc) begin
			acc_q <= (ctl.acc_first ? '0 : acc_q) + DST_W'(sq);
		end
		if (ctl.best_ld && (ctl.best_first || acc_q < best_q)) begin
			best_q <= acc_q;
			bi_q   <= c_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				cnt_q[i] <= '0;
			end
			moved_q  <= '0;
			energy_q <= '0;
			iter_q   <= '0;
		end else begin
			if (ctl.run_start) begin
				for (int i = 0; i < MAX_CLUSTERS; i++) begin
					cnt_q[i] <= '0;
				end
				energy_q <= '0;
			end
			if (ctl.cnt_inc) begin
				cnt_q[clu] <= cnt_q[clu] + 1'b1;
			end
			if (ctl.moved_clr) begin
				moved_q[clu] <= 1'b0;
			end
			if (upd_we) begin
				moved_q[clu] <= 1'b1;
			end
			if (ctl.energy_add && sqrt_done) begin
				energy_q <= energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
			end
			if (ctl.iter_inc && iter_q != '1) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			cluster_id      <= CLU_ID_W'(c_idx);
			coord_id        <= COORD_ID_W'(k_idx);
			centroid_value  <= cen_rdata;
			cluster_moved   <= moved_q[clu];
			total_energy    <= ctl.out_final ? energy_q : '0;
			iteration_count <= ctl.out_final ? iter_q : '0;
			out_final       <= ctl.out_final;
		end
	end

	assign stat.div_done  = div_done;
	assign stat.sqrt_done = sqrt_done;
	assign stat.cnt_zero  = cnt_q[clu] == '0;

endmodule

FILE: hw/rtl/kie_ctrl.sv
// controller: configuration registers, run sequencer and point/cluster/coordinate counters
module kie_ctrl
	import kie_pkg::*;
#(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_DIMS     = DEF_MAX_DIMS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [CFG_W-1:0]                cfg_wdata,
	input  logic                            s_valid,
	output logic                            s_ready,
	input  logic [CMD_W-1:0]                cmd,
	output logic                            m_valid,
	input  logic                            m_ready,
	input  kie_stat_t                       stat,
	output kie_ctl_t                        ctl,
	output logic [$clog2(MAX_POINTS)-1:0]   p_idx,
	output logic [$clog2(MAX_CLUSTERS)-1:0] c_idx,
	output logic [$clog2(MAX_DIMS)-1:0]     k_idx
);

	localparam int PIW = $clog2(MAX_POINTS);
	localparam int CIW = $clog2(MAX_CLUSTERS);
	localparam int KIW = $clog2(MAX_DIMS);
	localparam int ST_W = 5;

	localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
	localparam logic [ST_W-1:0] S_CLR      = 5'd1;
	localparam logic [ST_W-1:0] S_AD_RD    = 5'd2;
	localparam logic [ST_W-1:0] S_AD_SUB   = 5'd3;
	localparam logic [ST_W-1:0] S_AD_SQ    = 5'd4;
	localparam logic [ST_W-1:0] S_AD_CMP   = 5'd5;
	localparam logic [ST_W-1:0] S_AC_RD    = 5'd6;
	localparam logic [ST_W-1:0] S_AC_WR    = 5'd7;
	localparam logic [ST_W-1:0] S_UP_RD    = 5'd8;
	localparam logic [ST_W-1:0] S_UP_DIV   = 5'd9;
	localparam logic [ST_W-1:0] S_UP_WAIT  = 5'd10;
	localparam logic [ST_W-1:0] S_EN_CLS   = 5'd11;
	localparam logic [ST_W-1:0] S_EN_RD    = 5'd12;
	localparam logic [ST_W-1:0] S_EN_SUB   = 5'd13;
	localparam logic [ST_W-1:0] S_EN_SQ    = 5'd14;
	localparam logic [ST_W-1:0] S_EN_SQRT  = 5'd15;
	localparam logic [ST_W-1:0] S_EN_WAIT  = 5'd16;
	localparam logic [ST_W-1:0] S_OUT_RD   = 5'd17;
	localparam logic [ST_W-1:0] S_OUT_LD   = 5'd18;
	localparam logic [ST_W-1:0] S_OUT_WAIT = 5'd19;

	function automatic int clamp_cnt(int v, int hi);
		int r;
		r = v;
		if (v < 2) r = 2;
		else if (v > hi) r = hi;
		return r;
	endfunction

	logic [ST_W-1:0] state_q, state_d;
	logic [PIW-1:0]  p_q, p_d;
	logic [CIW-1:0]  c_q, c_d;
	logic [KIW-1:0]  k_q, k_d;
	logic [PC_W-1:0] pc_q;
	logic [KC_W-1:0] kc_q;
	logic [DC_W-1:0] dc_q;
	logic [PIW-1:0]  np_m1;
	logic [CIW-1:0]  nk_m1;
	logic [KIW-1:0]  nd_m1;
	logic            p_end, c_end, k_end;

	assign np_m1 = PIW'(clamp_cnt(int'(pc_q), MAX_POINTS) - 1);
	assign nk_m1 = CIW'(clamp_cnt(int'(kc_q), MAX_CLUSTERS) - 1);
	assign nd_m1 = KIW'(clamp_cnt(int'(dc_q), MAX_DIMS) - 1);
	assign p_end = p_q == np_m1;
	assign c_end = c_q == nk_m1;
	assign k_end = k_q == nd_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_W'(2);
			kc_q <= KC_W'(2);
			dc_q <= DC_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POINT_COUNT:   pc_q <= cfg_wdata[PC_W-1:0];
				CFG_CLUSTER_COUNT: kc_q <= cfg_wdata[KC_W-1:0];
				CFG_DIM_COUNT:     dc_q <= cfg_wdata[DC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		p_d     = p_q;
		c_d     = c_q;
		k_d     = k_q;
		ctl     = '0;
		ctl.clu_sel = SEL_CTR;
		s_ready = 1'b0;
		m_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					case (cmd)
						CMD_LOAD_POINT: ctl.ld_point = 1'b1;
						CMD_LOAD_CENT:  ctl.ld_cent  = 1'b1;
						CMD_RUN: begin
							ctl.run_start = 1'b1;
							c_d     = '0;
							k_d     = '0;
							state_d = S_CLR;
						end
						default: ;
					endcase
				end
			end
			// zero every cluster sum, one entry a cycle
			S_CLR: begin
				ctl.clr = 1'b1;
				if (k_q == KIW'(MAX_DIMS - 1)) begin
					k_d = '0;
					if (c_q == CIW'(MAX_CLUSTERS - 1)) begin
						p_d     = '0;
						c_d     = '0;
						state_d = S_AD_RD;
					end else begin
						c_d = c_q + 1'b1;
					end
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			S_AD_RD: begin
				ctl.pt_rd  = 1'b1;
				ctl.cen_rd = 1'b1;
				state_d    = S_AD_SUB;
			end
			S_AD_SUB: begin
				ctl.diff_ld = 1'b1;
				state_d     = S_AD_SQ;
			end
			S_AD_SQ: begin
				ctl.sq_acc    = 1'b1;
				ctl.acc_first = k_q == '0;
				if (k_end) begin
					state_d = S_AD_CMP;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_AD_RD;
				end
			end
			S_AD_CMP: begin
				ctl.best_ld    = 1'b1;
				ctl.best_first = c_q == '0;
				k_d = '0;
				if (c_end) begin
					state_d = S_AC_RD;
				end else begin
					c_d     = c_q + 1'b1;
					state_d = S_AD_RD;
				end
			end
			// add the point into its winning cluster
			S_AC_RD: begin
				ctl.clu_sel = SEL_BEST;
				ctl.pt_rd   = 1'b1;
				ctl.sum_rd  = 1'b1;
				ctl.cls_wr  = k_q == '0;
				ctl.cnt_inc = k_q == '0;
				state_d     = S_AC_WR;
			end
			S_AC_WR: begin
				ctl.clu_sel = SEL_BEST;
				ctl.acc_wr  = 1'b1;
				if (k_end) begin
					c_d = '0;
					k_d = '0;
					if (p_end) begin
						state_d = S_UP_RD;
					end else begin
						p_d     = p_q + 1'b1;
						state_d = S_AD_RD;
					end
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_AC_RD;
				end
			end
			S_UP_RD: begin
				ctl.sum_rd    = 1'b1;
				ctl.cen_rd    = 1'b1;
				ctl.moved_clr = k_q == '0;
				if (stat.cnt_zero) begin
					// empty cluster keeps its centroid
					k_d = '0;
					if (c_end) begin
						p_d     = '0;
						state_d = S_EN_CLS;
					end else begin
						c_d = c_q + 1'b1;
					end
				end else begin
					state_d = S_UP_DIV;
				end
			end
			S_UP_DIV: begin
				ctl.div_start = 1'b1;
				state_d       = S_UP_WAIT;
			end
			S_UP_WAIT: begin
				ctl.cent_upd = 1'b1;
				if (stat.div_done) begin
					if (k_end) begin
						k_d = '0;
						if (c_end) begin
							p_d     = '0;
							state_d = S_EN_CLS;
						end else begin
							c_d     = c_q + 1'b1;
							state_d = S_UP_RD;
						end
					end else begin
						k_d     = k_q + 1'b1;
						state_d = S_UP_RD;
					end
				end
			end
			S_EN_CLS: begin
				ctl.cls_rd = 1'b1;
				k_d        = '0;
				state_d    = S_EN_RD;
			end
			S_EN_RD: begin
				ctl.clu_sel = SEL_CLASS;
				ctl.pt_rd   = 1'b1;
				ctl.cen_rd  = 1'b1;
				state_d     = S_EN_SUB;
			end
			S_EN_SUB: begin
				ctl.diff_ld = 1'b1;
				state_d     = S_EN_SQ;
			end
			S_EN_SQ: begin
				ctl.sq_acc    = 1'b1;
				ctl.acc_first = k_q == '0;
				if (k_end) begin
					state_d = S_EN_SQRT;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_EN_RD;
				end
			end
			S_EN_SQRT: begin
				ctl.sqrt_start = 1'b1;
				state_d        = S_EN_WAIT;
			end
			S_EN_WAIT: begin
				ctl.energy_add = 1'b1;
				if (stat.sqrt_done) begin
					if (p_end) begin
						ctl.iter_inc = 1'b1;
						c_d          = '0;
						k_d          = '0;
						state_d      = S_OUT_RD;
					end else begin
						p_d     = p_q + 1'b1;
						state_d = S_EN_CLS;
					end
				end
			end
			S_OUT_RD: begin
				ctl.cen_rd = 1'b1;
				state_d    = S_OUT_LD;
			end
			S_OUT_LD: begin
				ctl.out_ld    = 1'b1;
				ctl.out_final = c_end && k_end;
				state_d       = S_OUT_WAIT;
			end
			S_OUT_WAIT: begin
				m_valid = 1'b1;
				if (m_ready) begin
					if (k_end) begin
						k_d = '0;
						if (c_end) begin
							c_d     = '0;
							state_d = S_IDLE;
						end else begin
							c_d     = c_q + 1'b1;
							state_d = S_OUT_RD;
						end
					end else begin
						k_d     = k_q + 1'b1;
						state_d = S_OUT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			p_q     <= p_d;
			c_q     <= c_d;
			k_q     <= k_d;
		end
	end

	assign p_idx = p_q;
	assign c_idx = c_q;
	assign k_idx = k_q;

endmodule

FILE: hw/rtl/kmeans_iteration_engine.sv
// top level of the k-means iteration engine: beat packing, controller and datapath
// Load beats (point or centroid coordinate) are taken one per cycle while the engine is idle.
// A run beat starts one Lloyd iteration: a sweep clears the cluster sums, assignment adds each
// point into the sum of its nearest cluster, each coordinate of a non-empty cluster is divided
// in the bit-serial divider, the energy pass sums the square-root unit's root of each point's
// distance, and the nk*nd result beats go out, held by any output stall.
// No beat is taken during a run.
// The last result beat carries total_energy and iteration_count; they read zero elsewhere.
module kmeans_iteration_engine
	import kie_pkg::*;
#(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_DIMS     = DEF_MAX_DIMS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// item_index, coord_index, coord_value
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// cmd
	input  logic [CMD_W-1:0]     s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// cluster_id, coord_id, centroid_value, cluster_moved, total_energy, iteration_count
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tlast
);

	localparam int PIW = $clog2(MAX_POINTS);
	localparam int CIW = $clog2(MAX_CLUSTERS);
	localparam int KIW = $clog2(MAX_DIMS);

	kie_ctl_t               ctl;
	kie_stat_t              stat;
	logic [PIW-1:0]         p_idx;
	logic [CIW-1:0]         c_idx;
	logic [KIW-1:0]         k_idx;
	logic [CLU_ID_W-1:0]    cluster_id;
	logic [COORD_ID_W-1:0]  coord_id;
	logic [COORD_W-1:0]     centroid_value;
	logic                   cluster_moved;
	logic [ENERGY_W-1:0]    total_energy;
	logic [ITER_W-1:0]      iteration_count;
	logic                   out_final;

	kie_ctrl #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_DIMS     (MAX_DIMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.cmd       (s_axis_tuser),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.stat      (stat),
		.ctl       (ctl),
		.p_idx     (p_idx),
		.c_idx     (c_idx),
		.k_idx     (k_idx)
	);

	kie_datapath #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_DIMS     (MAX_DIMS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.p_idx           (p_idx),
		.c_idx           (c_idx),
		.k_idx           (k_idx),
		.item_index      (s_axis_tdata[9:0]),
		.coord_index     (s_axis_tdata[12:10]),
		.coord_value     (s_axis_tdata[28:13]),
		.stat            (stat),
		.cluster_id      (cluster_id),
		.coord_id        (coord_id),
		.centroid_value  (centroid_value),
		.cluster_moved   (cluster_moved),
		.total_energy    (total_energy),
		.iteration_count (iteration_count),
		.out_final       (out_final)
	);

	assign m_axis_tdata = {1'b0, iteration_count, total_energy, cluster_moved,
		centroid_value, coord_id, cluster_id};
	assign m_axis_tlast = out_final;

endmodule

FILE: tb/kmeans_iteration_engine_tb.sv
// testbench for the k-means iteration engine: stream driver, centroid predictor and result checker
`timescale 1ns / 100ps

module kmeans_iteration_engine_tb;
	import kie_pkg::*;

	localparam int NPTS = DEF_MAX_POINTS;
	localparam int NCLU = DEF_MAX_CLUSTERS;
	localparam int NDIM = DEF_MAX_DIMS;
	localparam longint unsigned ENERGY_TOP = (64'd1 << ENERGY_W) - 1;
	localparam int CYCLE_LIMIT = 4000000;
	// command code the engine must ignore
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef struct {
		logic [CLU_ID_W-1:0]   cluster_id;
		logic [COORD_ID_W-1:0] coord_id;
		logic [COORD_W-1:0]    centroid_value;
		logic                  cluster_moved;
		logic [ENERGY_W-1:0]   total_energy;
		logic [ITER_W-1:0]     iteration_count;
		logic                  last;
	} centroid_beat_t;

	class lloyd_board;
		logic signed [COORD_W-1:0] points [NPTS][NDIM];
		logic signed [COORD_W-1:0] cents [NCLU][NDIM];
		bit pt_loaded [NPTS][NDIM];
		bit cen_loaded [NCLU][NDIM];
		int unsigned classes [NPTS];
		logic [PC_W-1:0] pc_reg = 2;
		logic [KC_W-1:0] kc_reg = 2;
		logic [DC_W-1:0] dc_reg = 2;
		int unsigned iters;
		int errors;
		int runs;
		int results;
		centroid_beat_t pending [$];

		function int eff(int v, int hi);
			if (v < 2) return 2;
			if (v > hi) return hi;
			return v;
		endfunction

		function int np_eff(); return eff(pc_reg, NPTS); endfunction
		function int nk_eff(); return eff(kc_reg, NCLU); endfunction
		function int nd_eff(); return eff(dc_reg, NDIM); endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				CFG_POINT_COUNT:   pc_reg = v[PC_W-1:0];
				CFG_CLUSTER_COUNT: kc_reg = v[KC_W-1:0];
				CFG_DIM_COUNT:     dc_reg = v[DC_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned dist_sq(int c, int p, int nd);
			longint unsigned acc;
			longint d;
			acc = 0;
			for (int k = 0; k < nd; k++) begin
				d = longint'(cents[c][k]) - longint'(points[p][k]);
				if (d < 0) d = -d;
				acc += longint'(d * d);
			end
			return acc;
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned rem, root, trial;
			rem = 0;
			root = 0;
			for (int i = 0; i < 32; i++) begin
				rem = (rem << 2) | (x >> 62);
				x = x << 2;
				root = root << 1;
				trial = (root << 1) | 1;
				if (rem >= trial) begin
					rem -= trial;
					root |= 1;
				end
			end
			return root;
		endfunction

		function void iterate();
			int np, nk, nd, bi;
			longint unsigned best, d, energy;
			longint sums [NCLU][NDIM];
			longint s, m;
			int cnt [NCLU];
			bit moved;
			centroid_beat_t e;
			np = np_eff();
			nk = nk_eff();
			nd = nd_eff();
			for (int p = 0; p < np; p++) begin
				best = dist_sq(0, p, nd);
				bi = 0;
				for (int c = 1; c < nk; c++) begin
					d = dist_sq(c, p, nd);
					if (d < best) begin
						best = d;
						bi = c;
					end
				end
				classes[p] = bi;
			end
			for (int c = 0; c < NCLU; c++) begin
				cnt[c] = 0;
				for (int k = 0; k < NDIM; k++) sums[c][k] = 0;
			end
			for (int p = 0; p < np; p++) begin
				cnt[classes[p]]++;
				for (int k = 0; k < nd; k++) begin
					s = sums[classes[p]][k] + longint'(points[p][k]);
					if (s > 64'sd2147483647) s = 64'sd2147483647;
					if (s < -64'sd2147483648) s = -64'sd2147483648;
					sums[classes[p]][k] = s;
				end
			end
			for (int c = 0; c < nk; c++) begin
				moved = 0;
				if (cnt[c] != 0) begin
					for (int k = 0; k < nd; k++) begin
						m = sums[c][k] / longint'(cnt[c]);
						if (m != longint'(cents[c][k])) begin
							cents[c][k] = m[COORD_W-1:0];
							moved = 1;
						end
					end
				end
				for (int k = 0; k < nd; k++) begin
					e.cluster_id = CLU_ID_W'(c);
					e.coord_id = COORD_ID_W'(k);
					e.centroid_value = cents[c][k];
					e.cluster_moved = moved;
					e.total_energy = '0;
					e.iteration_count = '0;
					e.last = 1'b0;
					pending.insert(pending.size(), e);
				end
			end
			energy = 0;
			for (int p = 0; p < np; p++) begin
				energy += int_sqrt(dist_sq(classes[p], p, nd));
				if (energy > ENERGY_TOP) energy = ENERGY_TOP;
			end
			if (iters < 65535) iters++;
			pending[pending.size() - 1].total_energy = ENERGY_W'(energy);
			pending[pending.size() - 1].iteration_count = ITER_W'(iters);
			pending[pending.size() - 1].last = 1'b1;
			runs++;
		endfunction

		function void note_beat(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] item,
				logic [2:0] ci, logic [COORD_W-1:0] val);
			case (cmd)
				CMD_LOAD_POINT: begin
					points[item][ci] = val;
					pt_loaded[item][ci] = 1;
				end
				CMD_LOAD_CENT: begin
					if (item < NCLU) begin
						cents[item][ci] = val;
						cen_loaded[item][ci] = 1;
					end
				end
				CMD_RUN: iterate();
				default: ;
			endcase
		endfunction

		function void check_centroid(logic [M_TDATA_W-1:0] td, logic tl);
			centroid_beat_t e;
			results++;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected: tdata=%h", td);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (td[2:0] !== e.cluster_id) begin
				$error("cluster_id: expected %0d, got %0d", e.cluster_id, td[2:0]);
				errors++;
			end
			if (td[5:3] !== e.coord_id) begin
				$error("coord_id: expected %0d, got %0d", e.coord_id, td[5:3]);
				errors++;
			end
			if (td[21:6] !== e.centroid_value) begin
				$error("centroid_value: expected %h, got %h", e.centroid_value, td[21:6]);
				errors++;
			end
			if (td[22] !== e.cluster_moved) begin
				$error("cluster_moved: expected %0d, got %0d", e.cluster_moved, td[22]);
				errors++;
			end
			if (td[70:23] !== e.total_energy) begin
				$error("total_energy: expected %0d, got %0d", e.total_energy, td[70:23]);
				errors++;
			end
			if (td[86:71] !== e.iteration_count) begin
				$error("iteration_count: expected %0d, got %0d", e.iteration_count, td[86:71]);
				errors++;
			end
			if (tl !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, tl);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// item_index, coord_index, coord_value
	logic [S_TDATA_W-1:0] s_axis_tdata;
	// cmd
	logic [CMD_W-1:0]     s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// cluster_id, coord_id, centroid_value, cluster_moved, total_energy, iteration_count
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tlast;

	lloyd_board board = new();
	int unsigned cycles = 0;
	bit tx_burst, rx_burst, rx_hold;
	int sent_items;

	kmeans_iteration_engine dut (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("kmeans_iteration_engine_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_beat(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[12:10],
				s_axis_tdata[28:13]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_centroid(m_axis_tdata, m_axis_tlast);
	end

	// receiver: random stalls, with one long hold-off on request
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				@(negedge clk) m_axis_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				rx_hold = 0;
			end
			n = rx_burst ? 0 : $urandom_range(0, 4);
			if (n > 0) begin
				@(negedge clk) m_axis_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk) m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_beat(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] item,
			logic [2:0] ci, logic [COORD_W-1:0] val);
		int n;
		n = tx_burst ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {3'b000, val, ci, item};
		do @(posedge clk); while (!s_axis_tready);
		sent_items++;
	endtask

	task automatic wait_idle();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		board.set_reg(idx, v);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// load whatever the next run would read and is still unwritten
	task automatic fill_stores();
		for (int p = 0; p < board.np_eff(); p++)
			for (int k = 0; k < board.nd_eff(); k++)
				if (!board.pt_loaded[p][k])
					send_beat(CMD_LOAD_POINT, ITEM_W'(p), 3'(k), COORD_W'($urandom));
		for (int c = 0; c < board.nk_eff(); c++)
			for (int k = 0; k < board.nd_eff(); k++)
				if (!board.cen_loaded[c][k])
					send_beat(CMD_LOAD_CENT, ITEM_W'(c), 3'(k), COORD_W'($urandom));
	endtask

	task automatic run_phase(int pc, int kc, int dc, int nloads, bit hold);
		int sel, np, nk, nd;
		wait_idle();
		write_reg(CFG_POINT_COUNT, CFG_W'(pc));
		write_reg(CFG_CLUSTER_COUNT, CFG_W'(kc));
		write_reg(CFG_DIM_COUNT, CFG_W'(dc));
		tx_burst = ($urandom_range(0, 3) == 0);
		rx_burst = ($urandom_range(0, 3) == 0);
		np = board.np_eff();
		nk = board.nk_eff();
		nd = board.nd_eff();
		for (int i = 0; i < nloads; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				send_beat(CMD_LOAD_POINT, ITEM_W'($urandom_range(0, np - 1)),
					3'($urandom_range(0, nd - 1)), COORD_W'($urandom));
			end else if (sel < 8) begin
				// centroid coordinate is either random or zero
				send_beat(CMD_LOAD_CENT, ITEM_W'($urandom_range(0, nk - 1)),
					3'($urandom_range(0, nd - 1)),
					$urandom_range(0, 1) ? COORD_W'($urandom) : 16'h0);
			end else if (sel == 8) begin
				send_beat(CMD_LOAD_POINT, ITEM_W'($urandom_range(0, NPTS - 1)),
					3'($urandom_range(0, 7)), COORD_W'($urandom));
			end else begin
				// noise: unknown command or out-of-range centroid
				send_beat($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_LOAD_CENT,
					ITEM_W'($urandom_range(NCLU, NPTS - 1)), 3'($urandom_range(0, 7)),
					COORD_W'($urandom));
			end
		end
		fill_stores();
		rx_hold = hold;
		send_beat(CMD_RUN, ITEM_W'($urandom), 3'($urandom), COORD_W'($urandom));
		// during a hold the next run beat waits at the input
		if (hold || $urandom_range(0, 1)) begin
			send_beat(CMD_RUN, 0, 0, 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_LOAD_POINT;
		tx_burst = 0;
		rx_burst = 0;
		rx_hold = 0;
		sent_items = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// tie between identical centroids keeps cluster 0, cluster 1 left empty
		send_beat(CMD_LOAD_POINT, 0, 0, 16'h0100);
		send_beat(CMD_LOAD_POINT, 0, 1, 16'hff00);
		send_beat(CMD_LOAD_POINT, 1, 0, 16'h0300);
		send_beat(CMD_LOAD_POINT, 1, 1, 16'h0080);
		send_beat(CMD_LOAD_CENT, 0, 0, 16'h0200);
		send_beat(CMD_LOAD_CENT, 0, 1, 16'h0000);
		send_beat(CMD_LOAD_CENT, 1, 0, 16'h0200);
		send_beat(CMD_LOAD_CENT, 1, 1, 16'h0000);
		send_beat(CMD_RUN, 0, 0, 0);
		// field extremes, ignored loads and the unknown command
		send_beat(CMD_LOAD_POINT, 0, 0, 16'h7fff);
		send_beat(CMD_LOAD_POINT, 1, 1, 16'h8000);
		send_beat(CMD_LOAD_POINT, 10'h3ff, 3'd7, 16'h8000);
		send_beat(CMD_LOAD_CENT, 1, 0, 16'h8000);
		send_beat(CMD_LOAD_CENT, 1, 1, 16'h7fff);
		send_beat(CMD_LOAD_CENT, 8, 0, 16'h1234);
		send_beat(CMD_LOAD_CENT, 10'h3ff, 3'd7, 16'hffff);
		send_beat(CMD_UNKNOWN, 10'h3ff, 3'd7, 16'hffff);
		send_beat(CMD_RUN, 10'h3ff, 3'd7, 16'hffff);
		send_beat(CMD_RUN, 0, 0, 0);

		// register extremes: below range, more clusters than points, at the maximum
		run_phase(0, 1, 0, 6, 0);
		run_phase(3, 8, 3, 10, 0);
		run_phase(2, 8, 8, 8, 1);
		while (sent_items < 280)
			run_phase($urandom_range(2, 16), $urandom_range(2, 8), $urandom_range(2, 8),
				$urandom_range(4, 30), 0);
		run_phase(12, 15, 15, 20, 0);
		run_phase(5, 2, 2, 10, 0);

		wait_idle();
		repeat (200) @(negedge clk);
		$display("ran %0d iterations over %0d input beats, checked %0d centroid beats",
			board.runs, sent_items, board.results);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("kmeans_iteration_engine_tb: done, clean");
		else
			$display("kmeans_iteration_engine_tb: done, errors");
		$finish;
	end

endmodule
